/* hdl/quaternion_to_euler_angles_unit_macros.svh */
// Assertion macros for the quaternion to Euler angle unit.
// Expects clk and arst_n in the scope of every use.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define QTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define QTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/qte_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, types and the CORDIC arctangent table for the quaternion to
// Euler angle unit. No dependencies.
`default_nettype none

package qte_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_MAX = 32;

	localparam int FLD_W  = 16;
	localparam int PROD_W = 32;
	localparam int ACC_W  = 36;
	localparam int TERM_W = 20;
	localparam int SQ_W   = 37;
	localparam int SUM_W  = 38;
	localparam int ROOT_W = 19;
	localparam int REM_W  = 21;
	localparam int CX_W   = 40;
	localparam int ANG_W  = 32;
	localparam int THR_W  = 8;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [THR_W-1:0]  THR_RESET     = 8'd1;

	localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// Rotation-matrix terms, Q14
	typedef struct packed {
		logic signed [TERM_W-1:0] m00;
		logic signed [TERM_W-1:0] m10;
		logic signed [TERM_W-1:0] m20;
		logic signed [TERM_W-1:0] m21;
		logic signed [TERM_W-1:0] m22;
		logic signed [TERM_W-1:0] m12;
		logic signed [TERM_W-1:0] m11;
	} terms_t;

	// One CORDIC vector in flight
	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic [ANG_W-1:0]       z;
		logic                   zero;
	} cvec_t;

endpackage

`default_nettype wire

/* hdl/qte_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interfaces: quaternion input and Euler angle output.
// No dependencies.
`default_nettype none

interface qte_quat_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               gimbal_lock;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
		input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
		output ready);
endinterface

`default_nettype wire

/* hdl/qte_sqrt_cell.sv */
`timescale 1ns / 1ps
// One cell of the digit-by-digit square root chain: settles one root bit.
// Depends on qte_pkg.
`default_nettype none

module qte_sqrt_cell
	import qte_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SUM_W-1:0]  n_d,
	input  wire logic [REM_W-1:0]  rem_d,
	input  wire logic [ROOT_W-1:0] root_d,
	input  wire terms_t            terms_d,
	output logic [SUM_W-1:0]       n_q,
	output logic [REM_W-1:0]       rem_q,
	output logic [ROOT_W-1:0]      root_q,
	output terms_t                 terms_q
);

	logic [REM_W+1:0] rem_t;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	// Bring down the next two radicand bits and try root*4+1
	always_comb begin
		rem_t = {rem_d, n_d[SUM_W-1 -: 2]};
		trial = {{(REM_W-ROOT_W){1'b0}}, root_d, 2'b01};
		ge    = rem_t >= trial;
		diff  = rem_t - trial;
	end

	// Advance one bit
	always_ff @(posedge clk) begin
		if (en) begin
			n_q     <= {n_d[SUM_W-3:0], 2'b00};
			rem_q   <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
			root_q  <= {root_d[ROOT_W-2:0], ge};
			terms_q <= terms_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/qte_cordic_cell.sv */
`timescale 1ns / 1ps
// One CORDIC vectoring micro-rotation with a fixed shift and angle.
// Depends on qte_pkg.
`default_nettype none

module qte_cordic_cell
	import qte_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire cvec_t d,
	output cvec_t      q
);

	logic signed [CX_W-1:0] dx;
	logic signed [CX_W-1:0] dy;
	cvec_t                  nxt;

	// Rotate toward the x axis by the sign of y
	always_comb begin
		dx       = d.y >>> STAGE;
		dy       = d.x >>> STAGE;
		nxt.zero = d.zero;
		if (d.y < 0) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ATAN_TAB[STAGE];
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ATAN_TAB[STAGE];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/quaternion_to_euler_angles_unit.sv */
`timescale 1ns / 1ps
// Top level: quaternion to roll/pitch/yaw conversion pipeline with APB register.
// Depends on qte_pkg, qte_stream_if, qte_sqrt_cell, qte_cordic_cell and the macros.
//
// Takes one Q2.14 quaternion per cycle when not stalled and returns roll, pitch
// and yaw as 16-bit binary angles plus a gimbal-lock flag, one result per quaternion
// in order. The pipeline is 4 front stages (products, matrix terms, squares, sum),
// 19 square root cells, one operand select stage, CORDIC_STAGES rotation cells
// (at most CORDIC_MAX) in three parallel rows, and one output register.
// Each stage stalls on its own, so empty slots fill while the output waits.
// Register 0 (byte address 0) is degenerate_threshold, reset 1.
`default_nettype none
`include "quaternion_to_euler_angles_unit_macros.svh"

module quaternion_to_euler_angles_unit
	import qte_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	qte_quat_if.sink               quat_in,
	qte_euler_if.source            euler_out,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	localparam int NCS    = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
	localparam int NSQ    = ROOT_W;
	localparam int ST_SQ0 = 4;
	localparam int ST_SEL = ST_SQ0 + NSQ;
	localparam int ST_CD0 = ST_SEL + 1;
	localparam int ST_OUT = ST_CD0 + NCS;
	localparam int NST    = ST_OUT + 1;
	localparam logic signed [ACC_W-1:0] ONE_Q28 = 36'sh0_1000_0000;
	localparam logic signed [ACC_W-1:0] HALF_Q14 = 36'sd8192;
	localparam logic signed [FLD_W-1:0] QUARTER = 16'sd16384;

	function automatic logic signed [TERM_W-1:0] to_q14(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = (v + HALF_Q14) >>> 14;
		return t[TERM_W-1:0];
	endfunction

	// Scale to CORDIC width, flag the zero vector, turn by pi when x is negative
	function automatic cvec_t prep(input logic signed [TERM_W-1:0] yv,
		input logic signed [TERM_W-1:0] xv);
		logic signed [CX_W-1:0] xs;
		logic signed [CX_W-1:0] ys;
		cvec_t r;
		xs = CX_W'(xv) <<< 16;
		ys = CX_W'(yv) <<< 16;
		r.zero = (xv == '0) && (yv == '0);
		if (xs < 0) begin
			r.x = -xs;
			r.y = -ys;
			r.z = 32'h8000_0000;
		end else begin
			r.x = xs;
			r.y = ys;
			r.z = '0;
		end
		return r;
	endfunction

	function automatic logic signed [FLD_W-1:0] angle16(input cvec_t v);
		logic [ANG_W-1:0] t;
		t = v.z + 32'h0000_8000;
		return v.zero ? '0 : t[ANG_W-1 -: FLD_W];
	endfunction

	// ---------------- configuration register ----------------
	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_THRESHOLD) ? APB_DW'(thr_q) : '0;

	// ---------------- stage valids and per-stage stall ----------------
	logic [NST-1:0] v_q;
	logic [NST-1:0] v_prev;
	logic [NST:0]   adv;

	always_comb begin
		adv[NST] = euler_out.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
		v_prev = {v_q[NST-2:0], quat_in.valid};
	end

	// Load a stage from its predecessor whenever it is free or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (v_q & ~adv[NST-1:0]) | (v_prev & adv[NST-1:0]);
		end
	end

	assign quat_in.ready = adv[0];

	// ---------------- products ----------------
	logic signed [PROD_W-1:0] xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			xx_s1 <= PROD_W'(quat_in.quat_x) * PROD_W'(quat_in.quat_x);
			yy_s1 <= PROD_W'(quat_in.quat_y) * PROD_W'(quat_in.quat_y);
			zz_s1 <= PROD_W'(quat_in.quat_z) * PROD_W'(quat_in.quat_z);
			xy_s1 <= PROD_W'(quat_in.quat_x) * PROD_W'(quat_in.quat_y);
			wz_s1 <= PROD_W'(quat_in.quat_w) * PROD_W'(quat_in.quat_z);
			xz_s1 <= PROD_W'(quat_in.quat_x) * PROD_W'(quat_in.quat_z);
			wy_s1 <= PROD_W'(quat_in.quat_w) * PROD_W'(quat_in.quat_y);
			yz_s1 <= PROD_W'(quat_in.quat_y) * PROD_W'(quat_in.quat_z);
			wx_s1 <= PROD_W'(quat_in.quat_w) * PROD_W'(quat_in.quat_x);
		end
	end

	// ---------------- matrix terms ----------------
	terms_t terms_c, terms_s2, terms_s3, terms_s4;

	always_comb begin
		terms_c.m00 = to_q14(ONE_Q28 - ((ACC_W'(yy_s1) + ACC_W'(zz_s1)) <<< 1));
		terms_c.m10 = to_q14((ACC_W'(xy_s1) + ACC_W'(wz_s1)) <<< 1);
		terms_c.m20 = to_q14((ACC_W'(xz_s1) - ACC_W'(wy_s1)) <<< 1);
		terms_c.m21 = to_q14((ACC_W'(yz_s1) + ACC_W'(wx_s1)) <<< 1);
		terms_c.m22 = to_q14(ONE_Q28 - ((ACC_W'(xx_s1) + ACC_W'(yy_s1)) <<< 1));
		terms_c.m12 = to_q14((ACC_W'(yz_s1) - ACC_W'(wx_s1)) <<< 1);
		terms_c.m11 = to_q14(ONE_Q28 - ((ACC_W'(xx_s1) + ACC_W'(zz_s1)) <<< 1));
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			terms_s2 <= terms_c;
		end
	end

	// ---------------- squares and sum ----------------
	logic signed [2*TERM_W-1:0] p00, p10;
	logic [SQ_W-1:0]            sq00_s3, sq10_s3;
	logic [SUM_W-1:0]           sum_s4;

	always_comb begin
		p00 = (2*TERM_W)'(terms_s2.m00) * (2*TERM_W)'(terms_s2.m00);
		p10 = (2*TERM_W)'(terms_s2.m10) * (2*TERM_W)'(terms_s2.m10);
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sq00_s3  <= p00[SQ_W-1:0];
			sq10_s3  <= p10[SQ_W-1:0];
			terms_s3 <= terms_s2;
		end
		if (adv[3]) begin
			sum_s4   <= {1'b0, sq00_s3} + {1'b0, sq10_s3};
			terms_s4 <= terms_s3;
		end
	end

	// ---------------- square root chain ----------------
	logic [SUM_W-1:0]  sq_n    [NSQ+1];
	logic [REM_W-1:0]  sq_rem  [NSQ+1];
	logic [ROOT_W-1:0] sq_root [NSQ+1];
	terms_t            sq_terms[NSQ+1];

	assign sq_n[0]     = sum_s4;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_terms[0] = terms_s4;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		qte_sqrt_cell u_cell (
			.clk     (clk),
			.en      (adv[ST_SQ0+k]),
			.n_d     (sq_n[k]),
			.rem_d   (sq_rem[k]),
			.root_d  (sq_root[k]),
			.terms_d (sq_terms[k]),
			.n_q     (sq_n[k+1]),
			.rem_q   (sq_rem[k+1]),
			.root_q  (sq_root[k+1]),
			.terms_q (sq_terms[k+1])
		);
	end

	// ---------------- branch select and CORDIC setup ----------------
	terms_t                   tt;
	logic                     lock_c;
	logic signed [TERM_W-1:0] cy_s;
	logic signed [TERM_W-1:0] roll_y, roll_x, yaw_y, yaw_x;
	cvec_t                    cv [3][NCS+1];
	logic                     lk_q [NCS+1];

	always_comb begin
		tt     = sq_terms[NSQ];
		cy_s   = $signed({1'b0, sq_root[NSQ]});
		lock_c = sq_root[NSQ] <= ROOT_W'(thr_q);
		roll_y = lock_c ? -tt.m12 : tt.m21;
		roll_x = lock_c ? tt.m11 : tt.m22;
		// A zero vector makes yaw come out as zero in gimbal lock
		yaw_y  = lock_c ? '0 : tt.m10;
		yaw_x  = lock_c ? '0 : tt.m00;
	end

	always_ff @(posedge clk) begin
		if (adv[ST_SEL]) begin
			cv[0][0] <= prep(-tt.m20, cy_s);
			cv[1][0] <= prep(roll_y, roll_x);
			cv[2][0] <= prep(yaw_y, yaw_x);
			lk_q[0]  <= lock_c;
		end
	end

	// ---------------- CORDIC rows: pitch, roll, yaw ----------------
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar k = 0; k < NCS; k++) begin : g_rot
			qte_cordic_cell #(
				.STAGE (k)
			) u_cell (
				.clk (clk),
				.en  (adv[ST_CD0+k]),
				.d   (cv[r][k]),
				.q   (cv[r][k+1])
			);
		end
	end

	for (genvar k = 0; k < NCS; k++) begin : g_lock
		always_ff @(posedge clk) begin
			if (adv[ST_CD0+k]) begin
				lk_q[k+1] <= lk_q[k];
			end
		end
	end

	// ---------------- rounding, pitch clamp, output register ----------------
	logic signed [FLD_W-1:0] pitch_c;
	logic signed [FLD_W-1:0] roll_q, pitch_q, yaw_q;
	logic                    lock_q;

	always_comb begin
		pitch_c = angle16(cv[0][NCS]);
		if (pitch_c > QUARTER) begin
			pitch_c = QUARTER;
		end else if (pitch_c < -QUARTER) begin
			pitch_c = -QUARTER;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_OUT]) begin
			roll_q  <= angle16(cv[1][NCS]);
			pitch_q <= pitch_c;
			yaw_q   <= angle16(cv[2][NCS]);
			lock_q  <= lk_q[NCS];
		end
	end

	assign euler_out.valid       = v_q[ST_OUT];
	assign euler_out.roll_angle  = roll_q;
	assign euler_out.pitch_angle = pitch_q;
	assign euler_out.yaw_angle   = yaw_q;
	assign euler_out.gimbal_lock = lock_q;

	// ---------------- assertions ----------------
	`QTE_ASSERT_IMP(a_lock_yaw_zero, euler_out.valid && euler_out.gimbal_lock,
		euler_out.yaw_angle == '0, "yaw nonzero in gimbal lock")
	`QTE_ASSERT_IMP(a_pitch_range, euler_out.valid,
		euler_out.pitch_angle <= QUARTER && euler_out.pitch_angle >= -QUARTER,
		"pitch outside half pi")
	`QTE_ASSERT_IMP(a_front_ready, !v_q[0], quat_in.ready,
		"empty front stage refused a transfer")
	`QTE_ASSERT_NXT(a_out_load, adv[ST_OUT] && v_q[ST_OUT-1], euler_out.valid,
		"finished result not loaded into output register")

endmodule

`default_nettype wire

/* sim/quaternion_to_euler_angles_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quaternion to Euler angle unit.
// Depends on qte_pkg, qte_stream_if and the quaternion_to_euler_angles_unit RTL.
`default_nettype none

module quaternion_to_euler_angles_unit_tb;
	import qte_pkg::*;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               lock;
	} euler_t;

	localparam int LATENCY = 25 + CORDIC_STAGES_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	qte_quat_if quat_bus ();
	qte_euler_if euler_bus ();

	quaternion_to_euler_angles_unit uut (
		.clk(clk), .arst_n(arst_n),
		.quat_in(quat_bus.sink), .euler_out(euler_bus.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	quat_t  pending_quats[$];
	euler_t expected_angles[$];
	logic [7:0] lock_threshold = THR_RESET;
	int mismatches = 0;
	int idle_cycles = 0;
	bit driver_enable = 1'b0;
	int hold_off = 0;

	// Floor shift of a signed value
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q14(longint q28);
		return fshr(q28 + 8192, 14);
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC; returns a 16-bit binary angle
	function automatic logic signed [15:0] cordic_angle(longint y, longint x);
		logic [31:0] acc = 32'd0;
		longint dx, dy;
		if (x == 0 && y == 0) return 16'sd0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 32'h80000000;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF && i < CORDIC_MAX; i++) begin
			dx = fshr(y, i);
			dy = fshr(x, i);
			if (y < 0) begin
				x -= dx; y += dy; acc -= ATAN_TAB[i];
			end else begin
				x += dx; y -= dy; acc += ATAN_TAB[i];
			end
		end
		acc = acc + 32'h8000;
		return acc[31:16];
	endfunction

	function automatic euler_t convert_quat(quat_t q);
		euler_t e;
		longint w = q.w, x = q.x, y = q.y, z = q.z;
		longint one = 64'sd1 <<< 28;
		longint m00, m10, m20, m21, m22, m12, m11, cy;
		logic signed [15:0] p;
		m00 = round_q14(one - 2 * (y * y + z * z));
		m10 = round_q14(2 * (x * y + w * z));
		m20 = round_q14(2 * (x * z - w * y));
		m21 = round_q14(2 * (y * z + w * x));
		m22 = round_q14(one - 2 * (x * x + y * y));
		m12 = round_q14(2 * (y * z - w * x));
		m11 = round_q14(one - 2 * (x * x + z * z));
		cy = int_sqrt(m00 * m00 + m10 * m10);
		e.lock = (cy <= lock_threshold);
		p = cordic_angle(-m20, cy);
		if (p > 16384) p = 16384;
		if (p < -16384) p = -16384;
		e.pitch = p;
		if (!e.lock) begin
			e.roll = cordic_angle(m21, m22);
			e.yaw = cordic_angle(m10, m00);
		end else begin
			e.roll = cordic_angle(-m12, m11);
			e.yaw = 16'sd0;
		end
		return e;
	endfunction

	// Driver: bursts and gaps, fed from the pending queue
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_bus.valid <= 1'b0;
			{quat_bus.quat_w, quat_bus.quat_x, quat_bus.quat_y, quat_bus.quat_z} <= '0;
		end else begin
			if (quat_bus.valid && quat_bus.ready) begin
				expected_angles.push_back(convert_quat({quat_bus.quat_w, quat_bus.quat_x,
					quat_bus.quat_y, quat_bus.quat_z}));
			end
			if (!quat_bus.valid || quat_bus.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					quat_bus.valid <= 1'b0;
				end else if (driver_enable && pending_quats.size() > 0) begin
					{quat_bus.quat_w, quat_bus.quat_x, quat_bus.quat_y, quat_bus.quat_z}
						<= pending_quats.pop_front();
					quat_bus.valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					quat_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: own stall pattern plus long hold-off stretches
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler_bus.ready <= 1'b0;
		end else begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				euler_bus.ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
				case (stall_mode)
					0: euler_bus.ready <= 1'b1;
					1: euler_bus.ready <= $urandom_range(0, 3) != 0;
					default: euler_bus.ready <= $urandom_range(0, 1) != 0;
				endcase
			end
		end
	end

	// Monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		euler_t got, want;
		if (arst_n && euler_bus.valid && euler_bus.ready) begin
			got = {euler_bus.roll_angle, euler_bus.pitch_angle, euler_bus.yaw_angle,
				euler_bus.gimbal_lock};
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_angles.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d lock %0b/%0b",
							want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw,
							want.lock, got.lock);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((quat_bus.valid && quat_bus.ready) || (euler_bus.valid && euler_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_threshold(logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= REG_THRESHOLD; pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		lock_threshold = value;
	endtask

	// Check at the falling edge so every update of the rising edge has settled
	task automatic wait_drained();
		driver_enable = 1'b1;
		while (pending_quats.size() > 0 || quat_bus.valid || expected_angles.size() > 0)
			@(negedge clk);
		driver_enable = 1'b0;
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2: return $signed(16'($urandom_range(0, 32))) - 16'sd16;
			default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
		endcase
	endfunction

	// Random quaternion, with some near gimbal lock
	function automatic quat_t rand_quat();
		quat_t q;
		int kind = $urandom_range(0, 9);
		if (kind < 3) begin
			q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
		end else if (kind < 5) begin
			// pitch near +-90: w = +-y, x = +-z
			q.w = $signed(16'($urandom_range(0, 23170))) - 16'sd11585;
			q.x = $signed(16'($urandom_range(0, 23170))) - 16'sd11585;
			q.y = $urandom_range(0, 1) ? q.w : -q.w;
			q.z = $urandom_range(0, 1) ? q.x : -q.x;
			q.y = q.y + $signed(16'($urandom_range(0, 8))) - 16'sd4;
		end else begin
			q.w = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
			q.x = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
			q.y = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
			q.z = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
		end
		return q;
	endfunction

	initial begin
		logic [7:0] settings [4] = '{8'd0, 8'd255, 8'd40, 8'd1};
		quat_bus.valid = 1'b0;
		euler_bus.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: identity, extremes, axes, zero and gimbal lock
		pending_quats.push_back({16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		pending_quats.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		pending_quats.push_back({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
		pending_quats.push_back({16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back({16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
		pending_quats.push_back({16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
		pending_quats.push_back({16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585});
		pending_quats.push_back({-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back({16'sd0, 16'sd0, 16'sd0, -16'sd16384});
		pending_quats.push_back({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
		pending_quats.push_back({16'sd1, -16'sd1, 16'sd1, -16'sd1});
		pending_quats.push_back({16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
		wait_drained();

		// Random phases across threshold settings
		foreach (settings[s]) begin
			write_threshold(settings[s]);
			for (int i = 0; i < 175; i++) pending_quats.push_back(rand_quat());
			if (s == 1) hold_off = 300;
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/qte_pkg.sv
hdl/qte_stream_if.sv
hdl/qte_sqrt_cell.sv
hdl/qte_cordic_cell.sv
hdl/quaternion_to_euler_angles_unit.sv
sim/quaternion_to_euler_angles_unit_tb.sv
